FILE: hdl/hdg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_pkg
// shared types, constants and the tangent table for the heading pipeline
// ----------------------------------------------------------------------------
package hdg_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int HEADING_W    = 9;
    localparam int M_TDATA_W    = ((HEADING_W + 7) / 8) * 8;
    localparam int TAN_COUNT    = 44;
    localparam int N_W          = $clog2(TAN_COUNT + 1);
    localparam int TAN_W        = 30;

    localparam logic [TAN_W-1:0] TAN_SCALE = 30'd1000000000;
    // above every scaled tangent and above the scale, so the test always fails
    localparam logic [TAN_W-1:0] TAN_NONE  = '1;

    localparam logic [HEADING_W-1:0] DEG_0   = 9'd0;
    localparam logic [HEADING_W-1:0] DEG_45  = 9'd45;
    localparam logic [HEADING_W-1:0] DEG_89  = 9'd89;
    localparam logic [HEADING_W-1:0] DEG_90  = 9'd90;
    localparam logic [HEADING_W-1:0] DEG_180 = 9'd180;
    localparam logic [HEADING_W-1:0] DEG_270 = 9'd270;
    localparam logic [HEADING_W-1:0] DEG_360 = 9'd360;

    typedef struct packed {
        logic dx_zero;
        logic dy_zero;
        logic dx_neg;
        logic dy_neg;
        logic equal;
        logic swap;
    } hdg_ctl_t;

    // tan(k deg) * 1e9 for k = idx + 1
    function automatic logic [TAN_W-1:0] tan_tab(input logic [N_W-1:0] idx);
        logic [TAN_W-1:0] t;
        unique case (idx)
            6'd0:  t = 30'd17455065;
            6'd1:  t = 30'd34920769;
            6'd2:  t = 30'd52407779;
            6'd3:  t = 30'd69926812;
            6'd4:  t = 30'd87488664;
            6'd5:  t = 30'd105104235;
            6'd6:  t = 30'd122784561;
            6'd7:  t = 30'd140540835;
            6'd8:  t = 30'd158384440;
            6'd9:  t = 30'd176326981;
            6'd10: t = 30'd194380309;
            6'd11: t = 30'd212556562;
            6'd12: t = 30'd230868191;
            6'd13: t = 30'd249328003;
            6'd14: t = 30'd267949192;
            6'd15: t = 30'd286745386;
            6'd16: t = 30'd305730681;
            6'd17: t = 30'd324919696;
            6'd18: t = 30'd344327613;
            6'd19: t = 30'd363970234;
            6'd20: t = 30'd383864035;
            6'd21: t = 30'd404026226;
            6'd22: t = 30'd424474816;
            6'd23: t = 30'd445228685;
            6'd24: t = 30'd466307658;
            6'd25: t = 30'd487732589;
            6'd26: t = 30'd509525449;
            6'd27: t = 30'd531709432;
            6'd28: t = 30'd554309051;
            6'd29: t = 30'd577350269;
            6'd30: t = 30'd600860619;
            6'd31: t = 30'd624869352;
            6'd32: t = 30'd649407593;
            6'd33: t = 30'd674508517;
            6'd34: t = 30'd700207538;
            6'd35: t = 30'd726542528;
            6'd36: t = 30'd753554050;
            6'd37: t = 30'd781285627;
            6'd38: t = 30'd809784033;
            6'd39: t = 30'd839099631;
            6'd40: t = 30'd869286738;
            6'd41: t = 30'd900404044;
            6'd42: t = 30'd932515086;
            6'd43: t = 30'd965688775;
            default: t = TAN_NONE;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/hdg_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_prep
// vector difference, magnitudes, octant flags and scaled minor magnitude
// ----------------------------------------------------------------------------
module hdg_prep #(
    parameter int COORD_BITS = 16,
    parameter int MAG_W      = COORD_BITS + 1,
    parameter int PROD_W     = MAG_W + 30
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  wire                       valid_in,
    input  wire  [COORD_BITS-1:0]     from_x,
    input  wire  [COORD_BITS-1:0]     from_y,
    input  wire  [COORD_BITS-1:0]     to_x,
    input  wire  [COORD_BITS-1:0]     to_y,
    output logic                      valid_out,
    output hdg_pkg::hdg_ctl_t         ctl_out,
    output logic [MAG_W-1:0]          b_out,
    output logic [PROD_W-1:0]         sprod_out
);
    import hdg_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    logic [MAG_W-1:0]  dx_reg, dy_reg;
    logic [MAG_W-1:0]  dx_next, dy_next;
    logic [MAG_W-1:0]  ux, uy;
    hdg_ctl_t          ctl2_reg, ctl2_next, ctl3_reg;
    logic [MAG_W-1:0]  s2_reg, b2_reg, s2_next, b2_next, b3_reg;
    logic [PROD_W-1:0] sprod_reg, sprod_next;

    // stage 1: differences, one bit wider than the coordinates
    assign dx_next = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
    assign dy_next = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};

    // stage 2: magnitudes and ordering
    always_comb begin
        ux = dx_reg[MAG_W-1] ? (~dx_reg + 1'b1) : dx_reg;
        uy = dy_reg[MAG_W-1] ? (~dy_reg + 1'b1) : dy_reg;
        ctl2_next.dx_zero = (dx_reg == '0);
        ctl2_next.dy_zero = (dy_reg == '0);
        ctl2_next.dx_neg  = dx_reg[MAG_W-1];
        ctl2_next.dy_neg  = dy_reg[MAG_W-1];
        ctl2_next.equal   = (ux == uy);
        ctl2_next.swap    = (ux < uy);
        s2_next = ctl2_next.swap ? ux : uy;
        b2_next = ctl2_next.swap ? uy : ux;
    end

    // stage 3: minor magnitude times the tangent scale
    assign sprod_next = PROD_W'(s2_reg) * PROD_W'(TAN_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            ctl2_reg  <= ctl2_next;
            s2_reg    <= s2_next;
            b2_reg    <= b2_next;
            ctl3_reg  <= ctl2_reg;
            b3_reg    <= b2_reg;
            sprod_reg <= sprod_next;
        end
    end

    assign valid_out = v3_reg;
    assign ctl_out   = ctl3_reg;
    assign b_out     = b3_reg;
    assign sprod_out = sprod_reg;

endmodule
`default_nettype wire

FILE: hdl/hdg_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_step
// one bit of the degree search: multiply major magnitude by a tangent, then
// compare against the scaled minor magnitude
// ----------------------------------------------------------------------------
module hdg_step #(
    parameter int MAG_W  = 17,
    parameter int PROD_W = MAG_W + 30,
    parameter int BIT    = 0
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           en,
    input  wire                           valid_in,
    input  hdg_pkg::hdg_ctl_t             ctl_in,
    input  wire  [MAG_W-1:0]              b_in,
    input  wire  [PROD_W-1:0]             sprod_in,
    input  wire  [hdg_pkg::N_W-1:0]       n_in,
    output logic                          valid_out,
    output hdg_pkg::hdg_ctl_t             ctl_out,
    output logic [MAG_W-1:0]              b_out,
    output logic [PROD_W-1:0]             sprod_out,
    output logic [hdg_pkg::N_W-1:0]       n_out
);
    import hdg_pkg::*;

    logic              va_reg, vb_reg;
    hdg_ctl_t          ctla_reg, ctlb_reg;
    logic [MAG_W-1:0]  ba_reg, bb_reg;
    logic [PROD_W-1:0] sa_reg, sb_reg;
    logic [N_W-1:0]    na_reg, nb_reg, nb_next;
    logic [N_W-1:0]    cand, cand_reg, idx;
    logic [PROD_W-1:0] prod_reg, prod_next;

    // candidate count with this bit set; tangent of (cand) degrees
    assign cand      = n_in | (N_W'(1) << BIT);
    assign idx       = cand - N_W'(1);
    assign prod_next = PROD_W'(b_in) * PROD_W'(tan_tab(idx));

    assign nb_next = (sa_reg >= prod_reg) ? cand_reg : na_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctla_reg <= ctl_in;
            ba_reg   <= b_in;
            sa_reg   <= sprod_in;
            na_reg   <= n_in;
            cand_reg <= cand;
            prod_reg <= prod_next;
            ctlb_reg <= ctla_reg;
            bb_reg   <= ba_reg;
            sb_reg   <= sa_reg;
            nb_reg   <= nb_next;
        end
    end

    assign valid_out = vb_reg;
    assign ctl_out   = ctlb_reg;
    assign b_out     = bb_reg;
    assign sprod_out = sb_reg;
    assign n_out     = nb_reg;

endmodule
`default_nettype wire

FILE: hdl/hdg_map.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hdg_map
// turns the octant degree count and the sign flags into the final heading
// ----------------------------------------------------------------------------
module hdg_map (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                en,
    input  wire                                valid_in,
    input  hdg_pkg::hdg_ctl_t                  ctl_in,
    input  wire  [hdg_pkg::N_W-1:0]            n_in,
    output logic                               valid_out,
    output logic [hdg_pkg::HEADING_W-1:0]      heading
);
    import hdg_pkg::*;

    logic                 valid_reg;
    logic [HEADING_W-1:0] heading_reg, heading_next;
    logic [HEADING_W-1:0] fl, ce;

    always_comb begin
        // floor and ceiling of the first-quadrant angle
        if (ctl_in.equal) begin
            fl = DEG_45;
            ce = DEG_45;
        end else begin
            fl = ctl_in.swap ? (DEG_89 - HEADING_W'(n_in)) : HEADING_W'(n_in);
            ce = fl + HEADING_W'(1);
        end

        priority if (ctl_in.dx_zero) begin
            heading_next = ctl_in.dy_zero ? DEG_0 : (ctl_in.dy_neg ? DEG_90 : DEG_270);
        end else if (ctl_in.dy_zero) begin
            heading_next = ctl_in.dx_neg ? DEG_180 : DEG_360;
        end else if (!ctl_in.dx_neg && ctl_in.dy_neg) begin
            heading_next = fl;
        end else if (ctl_in.dx_neg && ctl_in.dy_neg) begin
            heading_next = DEG_180 - ce;
        end else if (ctl_in.dx_neg) begin
            heading_next = DEG_180 + fl;
        end else begin
            heading_next = DEG_360 - ce;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            heading_reg <= heading_next;
        end
    end

    assign valid_out = valid_reg;
    assign heading   = heading_reg;

endmodule
`default_nettype wire

FILE: hdl/heading_angle_degrees.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heading_angle_degrees
// throughput: one word per cycle; 3 prep stages, 6 search bits of 2 stages
// each (tangent multiply, compare), 1 output stage
// the whole pipeline holds when the output word is not taken
// reset clears the stage valid bits only; no stored state otherwise
// ----------------------------------------------------------------------------
module heading_angle_degrees #(
    parameter int COORD_BITS = hdg_pkg::COORD_BITS_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    // from_x, from_y, to_x, to_y, zero pad
    input  wire  [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    // heading, zero pad
    output logic [hdg_pkg::M_TDATA_W-1:0]          m_tdata
);
    import hdg_pkg::*;

    localparam int MAG_W  = COORD_BITS + 1;
    localparam int PROD_W = MAG_W + TAN_W;

    logic                 en;
    logic                 valid_pipe [0:N_W];
    hdg_ctl_t             ctl_pipe   [0:N_W];
    logic [MAG_W-1:0]     b_pipe     [0:N_W];
    logic [PROD_W-1:0]    sprod_pipe [0:N_W];
    logic [N_W-1:0]       n_pipe     [0:N_W];
    logic [HEADING_W-1:0] heading;

    assign en       = m_tready | ~m_tvalid;
    assign s_tready = en;

    hdg_prep #(
        .COORD_BITS (COORD_BITS),
        .MAG_W      (MAG_W),
        .PROD_W     (PROD_W)
    ) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_tvalid),
        .from_x    (s_tdata[COORD_BITS-1:0]),
        .from_y    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .to_x      (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .to_y      (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
        .valid_out (valid_pipe[0]),
        .ctl_out   (ctl_pipe[0]),
        .b_out     (b_pipe[0]),
        .sprod_out (sprod_pipe[0])
    );

    assign n_pipe[0] = '0;

    // binary search over the tangent table, most significant bit first
    for (genvar i = 0; i < N_W; i++) begin : g_step
        hdg_step #(
            .MAG_W  (MAG_W),
            .PROD_W (PROD_W),
            .BIT    (N_W - 1 - i)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (valid_pipe[i]),
            .ctl_in    (ctl_pipe[i]),
            .b_in      (b_pipe[i]),
            .sprod_in  (sprod_pipe[i]),
            .n_in      (n_pipe[i]),
            .valid_out (valid_pipe[i+1]),
            .ctl_out   (ctl_pipe[i+1]),
            .b_out     (b_pipe[i+1]),
            .sprod_out (sprod_pipe[i+1]),
            .n_out     (n_pipe[i+1])
        );
    end

    hdg_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (valid_pipe[N_W]),
        .ctl_in    (ctl_pipe[N_W]),
        .n_in      (n_pipe[N_W]),
        .valid_out (m_tvalid),
        .heading   (heading)
    );

    assign m_tdata = {{(M_TDATA_W-HEADING_W){1'b0}}, heading};

endmodule
`default_nettype wire
